>>> hdl/odometry_frame_to_centre_pose_assert.svh
// ----------------------------------------------------------------------------
// Odometry frame to centre pose assertion macros
// Concurrent checks, sampled on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ODOMETRY_FRAME_TO_CENTRE_POSE_ASSERT_SVH
`define ODOMETRY_FRAME_TO_CENTRE_POSE_ASSERT_SVH

// Plain check of a property on every clock edge out of reset.
`define OFCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when cond holds, res must hold in the same cycle.
`define OFCP_ASSERT_IMP(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (res)) \
    else $error(msg);

`endif

>>> hdl/ofcp_pkg.sv
// ----------------------------------------------------------------------------
// Odometry frame to centre pose package
// Shared types, register codes, reset values and CORDIC constants.
// ----------------------------------------------------------------------------
package ofcp_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned ADDR_W = 5;

  localparam logic [31:0] POS_SCALE_RST  = 32'd1310720000;
  localparam logic [31:0] HDG_SCALE_RST  = 32'd411775;
  localparam logic [31:0] VEL_SCALE_RST  = 32'd655360000;
  localparam logic [31:0] RATE_SCALE_RST = 32'd4575277;

  localparam logic signed [32:0] Q28_PI      = 33'sd843314857;
  localparam logic signed [32:0] Q28_TWO_PI  = 33'sd1686629713;
  localparam logic signed [32:0] Q28_HALF_PI = 33'sd421657428;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  // Bound on the CORDIC magnitude, unit vector plus a few LSB of drift.
  localparam logic signed [31:0] UNIT_BOUND  = 32'sd1073741888;

  localparam logic signed [31:0] ATAN_Q28 [32] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32, 32'sd16, 32'sd8, 32'sd4, 32'sd2, 32'sd1, 32'sd0, 32'sd0, 32'sd0
  };

  typedef enum logic [2:0] {
    REG_POS_SCALE  = 3'd0,
    REG_HDG_SCALE  = 3'd1,
    REG_VEL_SCALE  = 3'd2,
    REG_RATE_SCALE = 3'd3,
    REG_MOUNT_YAW  = 3'd4,
    REG_LEVER_X    = 3'd5,
    REG_LEVER_Y    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]        pos_scale;
    logic [31:0]        hdg_scale;
    logic [31:0]        vel_scale;
    logic [31:0]        rate_scale;
    logic signed [30:0] mount_yaw;
    logic signed [31:0] lever_x;
    logic signed [31:0] lever_y;
  } cfg_t;

endpackage

>>> hdl/ofcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Odometry frame to centre pose configuration registers
// APB-style register file holding scales, mounting yaw and lever arm.
// ----------------------------------------------------------------------------
module ofcp_cfg_regs import ofcp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_scale  <= POS_SCALE_RST;
      cfg_q.hdg_scale  <= HDG_SCALE_RST;
      cfg_q.vel_scale  <= VEL_SCALE_RST;
      cfg_q.rate_scale <= RATE_SCALE_RST;
      cfg_q.mount_yaw  <= '0;
      cfg_q.lever_x    <= '0;
      cfg_q.lever_y    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_POS_SCALE:  cfg_q.pos_scale  <= pwdata;
        REG_HDG_SCALE:  cfg_q.hdg_scale  <= pwdata;
        REG_VEL_SCALE:  cfg_q.vel_scale  <= pwdata;
        REG_RATE_SCALE: cfg_q.rate_scale <= pwdata;
        REG_MOUNT_YAW:  cfg_q.mount_yaw  <= $signed(pwdata[30:0]);
        REG_LEVER_X:    cfg_q.lever_x    <= $signed(pwdata);
        REG_LEVER_Y:    cfg_q.lever_y    <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_SCALE:  prdata = cfg_q.pos_scale;
      REG_HDG_SCALE:  prdata = cfg_q.hdg_scale;
      REG_VEL_SCALE:  prdata = cfg_q.vel_scale;
      REG_RATE_SCALE: prdata = cfg_q.rate_scale;
      REG_MOUNT_YAW:  prdata = {cfg_q.mount_yaw[30], cfg_q.mount_yaw};
      REG_LEVER_X:    prdata = cfg_q.lever_x;
      REG_LEVER_Y:    prdata = cfg_q.lever_y;
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hdl/ofcp_cordic.sv
// ----------------------------------------------------------------------------
// Odometry frame to centre pose CORDIC
// Pipelined rotation-mode CORDIC: Q.28 angle in, Q.30 cosine and sine out.
// ----------------------------------------------------------------------------
module ofcp_cordic import ofcp_pkg::*; #(
  parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] angle_i,
  output logic               valid_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int unsigned XW = 34;

  logic signed [32:0]   a_ext;
  logic signed [32:0]   a_w_d;
  logic signed [32:0]   a_w_q;
  logic                 vld_w_q;
  logic signed [32:0]   a_f;
  logic                 neg_f;

  logic signed [XW-1:0] x_q   [0:STEPS];
  logic signed [XW-1:0] y_q   [0:STEPS];
  logic signed [31:0]   z_q   [0:STEPS];
  logic                 neg_q [0:STEPS];
  logic                 vld_q [0:STEPS];

  logic signed [31:0]   cos_q;
  logic signed [31:0]   sin_q;
  logic                 vld_o_q;

  // Wrap into [-pi, pi]; one correction covers the whole input range.
  assign a_ext = {angle_i[31], angle_i};
  always_comb begin
    if (a_ext > Q28_PI)       a_w_d = a_ext - Q28_TWO_PI;
    else if (a_ext < -Q28_PI) a_w_d = a_ext + Q28_TWO_PI;
    else                      a_w_d = a_ext;
  end

  // Fold into [-pi/2, pi/2]; remember to negate the result.
  always_comb begin
    if (a_w_q > Q28_HALF_PI) begin
      a_f   = a_w_q - Q28_PI;
      neg_f = 1'b1;
    end else if (a_w_q < -Q28_HALF_PI) begin
      a_f   = a_w_q + Q28_PI;
      neg_f = 1'b1;
    end else begin
      a_f   = a_w_q;
      neg_f = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_w_q  <= 1'b0;
      vld_q[0] <= 1'b0;
      vld_o_q  <= 1'b0;
    end else if (en_i) begin
      vld_w_q  <= valid_i;
      vld_q[0] <= vld_w_q;
      vld_o_q  <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_w_q    <= a_w_d;
      x_q[0]   <= GAIN_Q30;
      y_q[0]   <= '0;
      z_q[0]   <= a_f[31:0];
      neg_q[0] <= neg_f;
      cos_q    <= neg_q[STEPS] ? 32'(-x_q[STEPS]) : x_q[STEPS][31:0];
      sin_q    <= neg_q[STEPS] ? 32'(-y_q[STEPS]) : y_q[STEPS][31:0];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN_Q28[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN_Q28[i];
        end
      end
    end
  end

  assign valid_o = vld_o_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

>>> hdl/odometry_frame_to_centre_pose.sv
// ----------------------------------------------------------------------------
// Odometry frame to centre pose
// Scales a raw odometry frame, rotates it out of the sensor frame and moves
// the position from the sensor to the robot centre.
// ----------------------------------------------------------------------------
// Accepts one frame per cycle while no stall holds the output. A beat passes
// through the scale multiply and rounding registers, the pipelined CORDIC
// (wrap, fold, one stage per iteration, sign fix), then the rotation multiply,
// the rounded sums and the saturating output register, in that order.
// The pipeline advances as a whole whenever the output register is empty or
// its beat is taken, so a stall on the master side freezes every stage and
// loses nothing. Two CORDICs run in lockstep: one on minus the mounting yaw,
// one on the scaled heading. Configuration registers sit on the APB-style
// port, byte address 4*index.
// ----------------------------------------------------------------------------
`include "odometry_frame_to_centre_pose_assert.svh"

module odometry_frame_to_centre_pose import ofcp_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // raw_pos_x, raw_pos_y, raw_heading, raw_vel_x, raw_vel_y, raw_rate
  input  logic [95:0]       s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // centre_x, centre_y, heading_out, vel_x_out, vel_y_out, rate_out
  output logic [191:0]      m_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned LAT = CORDIC_STEPS + 3;

  typedef struct packed {
    logic signed [28:0] px;
    logic signed [28:0] py;
    logic signed [28:0] vx;
    logic signed [28:0] vy;
    logic signed [31:0] hd;
    logic signed [31:0] rt;
  } pass_t;

  cfg_t cfg;
  logic advance;

  ofcp_cfg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // Freeze the whole pipeline while a finished beat waits.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // ---- stage A: scale multiplies, exact Q.32 products ----
  logic signed [48:0] prod_q [6];
  logic               vld_a_q;

  function automatic logic signed [48:0] scale_mul(logic [15:0] raw, logic [31:0] sc);
    logic signed [48:0] r;
    logic signed [48:0] s;
    r = $signed({{33{raw[15]}}, raw});
    s = $signed({17'd0, sc});
    return r * s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_q[0] <= scale_mul(s_axis_tdata[15:0],  cfg.pos_scale);
      prod_q[1] <= scale_mul(s_axis_tdata[31:16], cfg.pos_scale);
      prod_q[2] <= scale_mul(s_axis_tdata[47:32], cfg.hdg_scale);
      prod_q[3] <= scale_mul(s_axis_tdata[63:48], cfg.vel_scale);
      prod_q[4] <= scale_mul(s_axis_tdata[79:64], cfg.vel_scale);
      prod_q[5] <= scale_mul(s_axis_tdata[95:80], cfg.rate_scale);
    end
  end

  // ---- stage B: round half up to output formats, saturate heading and rate ----
  function automatic logic signed [31:0] sat32(logic signed [48:0] v);
    if (v > 49'sd2147483647)       return 32'sh7fffffff;
    else if (v < -49'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  logic signed [48:0] rnd_px, rnd_py, rnd_vx, rnd_vy, rnd_hd, rnd_rt;
  pass_t              b_d, b_q;
  logic               vld_b_q;

  assign rnd_px = (prod_q[0] + 49'sd524288) >>> 20;
  assign rnd_py = (prod_q[1] + 49'sd524288) >>> 20;
  assign rnd_hd = (prod_q[2] + 49'sd8) >>> 4;
  assign rnd_vx = (prod_q[3] + 49'sd524288) >>> 20;
  assign rnd_vy = (prod_q[4] + 49'sd524288) >>> 20;
  assign rnd_rt = (prod_q[5] + 49'sd2048) >>> 12;

  always_comb begin
    b_d.px = rnd_px[28:0];
    b_d.py = rnd_py[28:0];
    b_d.vx = rnd_vx[28:0];
    b_d.vy = rnd_vy[28:0];
    b_d.hd = sat32(rnd_hd);
    b_d.rt = sat32(rnd_rt);
  end

  always_ff @(posedge clk_i) begin
    if (advance) b_q <= b_d;
  end

  // ---- CORDICs: minus mounting yaw and scaled heading ----
  logic signed [31:0] yaw_neg;
  logic signed [31:0] cm, sm, ch, sh;
  logic               mnt_vld, hdg_vld;

  assign yaw_neg = -$signed({cfg.mount_yaw[30], cfg.mount_yaw});

  ofcp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_mnt (
    .clk_i, .rst_ni, .en_i(advance), .valid_i(vld_b_q), .angle_i(yaw_neg),
    .valid_o(mnt_vld), .cos_o(cm), .sin_o(sm)
  );

  ofcp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_hdg (
    .clk_i, .rst_ni, .en_i(advance), .valid_i(vld_b_q), .angle_i(b_q.hd),
    .valid_o(hdg_vld), .cos_o(ch), .sin_o(sh)
  );

  // Hold the scaled frame alongside the CORDIC latency.
  pass_t dly_q     [0:LAT-1];
  logic  dly_vld_q [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dly_q[0] <= b_q;
      for (int k = 1; k < LAT; k++) dly_q[k] <= dly_q[k-1];
    end
  end

  // ---- stage R1: rotation products ----
  logic signed [63:0] m_q [12];
  logic signed [31:0] hd_r1_q, rt_r1_q;
  logic               vld_r1_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_q[0]  <= cm * dly_q[LAT-1].px;
      m_q[1]  <= sm * dly_q[LAT-1].py;
      m_q[2]  <= sm * dly_q[LAT-1].px;
      m_q[3]  <= cm * dly_q[LAT-1].py;
      m_q[4]  <= cm * dly_q[LAT-1].vx;
      m_q[5]  <= sm * dly_q[LAT-1].vy;
      m_q[6]  <= sm * dly_q[LAT-1].vx;
      m_q[7]  <= cm * dly_q[LAT-1].vy;
      m_q[8]  <= ch * cfg.lever_x;
      m_q[9]  <= sh * cfg.lever_y;
      m_q[10] <= sh * cfg.lever_x;
      m_q[11] <= ch * cfg.lever_y;
      hd_r1_q <= dly_q[LAT-1].hd;
      rt_r1_q <= dly_q[LAT-1].rt;
    end
  end

  // ---- stage R2: exact sums rounded half up to Q.12 ----
  function automatic logic signed [34:0] rsum(logic signed [63:0] a, logic signed [63:0] b,
                                              logic sub);
    logic signed [64:0] s;
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    s = (s + 65'sd536870912) >>> 30;
    return s[34:0];
  endfunction

  logic signed [34:0] rx_q, ry_q, rvx_q, rvy_q, lx_q, ly_q;
  logic signed [31:0] hd_r2_q, rt_r2_q;
  logic               vld_r2_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rx_q    <= rsum(m_q[0],  m_q[1],  1'b1);
      ry_q    <= rsum(m_q[2],  m_q[3],  1'b0);
      rvx_q   <= rsum(m_q[4],  m_q[5],  1'b1);
      rvy_q   <= rsum(m_q[6],  m_q[7],  1'b0);
      lx_q    <= rsum(m_q[8],  m_q[9],  1'b1);
      ly_q    <= rsum(m_q[10], m_q[11], 1'b0);
      hd_r2_q <= hd_r1_q;
      rt_r2_q <= rt_r1_q;
    end
  end

  // ---- stage R3: subtract lever arm, saturate, output register ----
  function automatic logic signed [31:0] sat36(logic signed [35:0] v);
    if (v > 36'sd2147483647)       return 32'sh7fffffff;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  logic [191:0] out_q;
  logic         vld_o_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {rt_r2_q, sat36(36'(rvy_q)), sat36(36'(rvx_q)), hd_r2_q,
                sat36(36'(ry_q) - 36'(ly_q)), sat36(36'(rx_q) - 36'(lx_q))};
    end
  end

  // Valid bits of every stage travel with their data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      for (int k = 0; k < LAT; k++) dly_vld_q[k] <= 1'b0;
      vld_r1_q <= 1'b0;
      vld_r2_q <= 1'b0;
      vld_o_q  <= 1'b0;
    end else if (advance) begin
      vld_a_q      <= s_axis_tvalid;
      vld_b_q      <= vld_a_q;
      dly_vld_q[0] <= vld_b_q;
      for (int k = 1; k < LAT; k++) dly_vld_q[k] <= dly_vld_q[k-1];
      vld_r1_q     <= dly_vld_q[LAT-1];
      vld_r2_q     <= vld_r1_q;
      vld_o_q      <= vld_r2_q;
    end
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = vld_o_q;

  // ---- assertions ----
  `OFCP_ASSERT(a_cordic_lockstep, mnt_vld == hdg_vld, "CORDIC pipelines out of step")
  `OFCP_ASSERT(a_dly_align, hdg_vld == dly_vld_q[LAT-1], "frame delay misaligned with CORDIC")
  `OFCP_ASSERT_IMP(a_unit_cos, mnt_vld, (cm <= UNIT_BOUND) && (cm >= -UNIT_BOUND),
                   "mount cosine beyond unit magnitude")

endmodule
